// ----- sv/rkbs_pkg.sv -----
package rkbs_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int KEY_BITS    = 32;
  localparam int TAG_BITS    = 5;
  localparam int FUNC_BITS   = 2;
  localparam int ADDR_BITS   = $clog2(MAX_RECORDS);
  localparam int CNT_BITS    = $clog2(MAX_RECORDS + 1);
  localparam int REC_BITS    = KEY_BITS + TAG_BITS;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [FUNC_BITS-1:0] func_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [REC_BITS-1:0]  rec_t;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SORT  = 2'd1,
    FUNC_CLEAR = 2'd2
  } rkbs_func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_START,
    ST_FIRST,
    ST_CMP,
    ST_TAIL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } rkbs_state_t;

endpackage

// ----- sv/rkbs_ifs.sv -----
interface rkbs_in_if;
  logic                  valid;
  logic                  ready;
  rkbs_pkg::func_t       func;
  rkbs_pkg::key_t        key_value;
  rkbs_pkg::tag_t        payload_tag;

  modport source (output valid, output func, output key_value, output payload_tag,
                  input ready);
  modport sink   (input valid, input func, input key_value, input payload_tag,
                  output ready);
endinterface

interface rkbs_out_if;
  logic                  valid;
  logic                  ready;
  rkbs_pkg::key_t        sorted_key;
  rkbs_pkg::tag_t        sorted_tag;
  logic                  last;

  modport source (output valid, output sorted_key, output sorted_tag, output last,
                  input ready);
  modport sink   (input valid, input sorted_key, input sorted_tag, input last,
                  output ready);
endinterface

interface rkbs_cfg_if;
  logic valid;
  logic ready;
  logic descending;

  modport source (output valid, output descending, input ready);
  modport sink   (input valid, input descending, output ready);
endinterface

// ----- sv/rkbs_ram.sv -----
module rkbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/record_key_bubble_sort.sv -----
// Channel | Dir | Payload                                  | Handshake
// in_ch   | in  | func, key_value[31:0], payload_tag[4:0]   | valid/ready
// out_ch  | out | sorted_key[31:0], sorted_tag[4:0], last   | valid/ready
// cfg_ch  | in  | descending                               | valid/ready (always ready)
//
// Load and clear items are handled in ST_IDLE, so the block stays ready for further items.
// A sort item of n records runs n-1 bubble passes over the record RAM, each made of
// pass setup, one read/compare/write-back per neighbor pair and the tail write, then
// streams one record per cycle out of the RAM read port; output back-pressure stalls
// the emit stream in place. Synchronous active-low reset clears the record count, the
// sequencer, out valid and the sort order; the RAM contents are not reset.
module record_key_bubble_sort (
  input  logic          clk,
  input  logic          rst_n,
  rkbs_in_if.sink       in_ch,
  rkbs_out_if.source    out_ch,
  rkbs_cfg_if.sink      cfg_ch
);
  import rkbs_pkg::*;

  rkbs_state_t state_r, state_nxt;
  cnt_t        count_r, count_nxt;
  addr_t       last_r, last_nxt;     // highest position of the current pass
  addr_t       pos_r, pos_nxt;       // position being written back
  addr_t       idx_r, idx_nxt;       // emit position
  rec_t        carry_r, carry_nxt;   // record bubbling through the pass
  logic        descending_r;

  logic        out_valid_r, out_valid_nxt;
  key_t        out_key_r, out_key_nxt;
  tag_t        out_tag_r, out_tag_nxt;
  logic        out_last_r, out_last_nxt;

  // RAM port controls
  logic        ram_we, ram_re;
  addr_t       ram_waddr, ram_raddr;
  rec_t        ram_wdata, ram_rdata;

  logic        in_fire;
  logic        out_free;
  logic        out_load;
  logic        swap;
  logic        pass_more;
  logic        emit_final;
  key_t        carry_key, rd_key;

  rkbs_ram #(
    .WIDTH (REC_BITS),
    .DEPTH (MAX_RECORDS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sorted_key = out_key_r;
  assign out_ch.sorted_tag = out_tag_r;
  assign out_ch.last       = out_last_r;

  // Compare the carried (earlier) record against the one just read.
  // Exchange only on strict inequality so equal keys keep load order.
  assign carry_key  = carry_r[REC_BITS-1 -: KEY_BITS];
  assign rd_key     = ram_rdata[REC_BITS-1 -: KEY_BITS];
  assign swap       = descending_r ? (carry_key < rd_key) : (carry_key > rd_key);
  assign pass_more  = (pos_r + addr_t'(1)) != last_r;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign emit_final = (cnt_t'(idx_r) + cnt_t'(1)) == count_r;
  assign out_load   = (state_r == ST_EMIT_LD) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && rkbs_func_t'(in_ch.func) == FUNC_SORT) begin
          if (count_r == cnt_t'(1)) begin
            state_nxt = ST_EMIT_RD;
          end else if (count_r != cnt_t'(0)) begin
            state_nxt = ST_PASS_START;
          end
        end
      end
      ST_PASS_START: state_nxt = ST_FIRST;
      ST_FIRST:      state_nxt = ST_CMP;
      ST_CMP: begin
        if (!pass_more) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = (last_r == addr_t'(1)) ? ST_EMIT_RD : ST_PASS_START;
      end
      ST_EMIT_RD:    state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free && emit_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    count_nxt    = count_r;
    last_nxt     = last_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    carry_nxt    = carry_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = carry_r;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    out_key_nxt  = out_key_r;
    out_tag_nxt  = out_tag_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (rkbs_func_t'(in_ch.func))
            FUNC_LOAD: begin
              if (count_r < cnt_t'(MAX_RECORDS)) begin
                ram_we    = 1'b1;
                ram_waddr = addr_t'(count_r);
                ram_wdata = {in_ch.key_value, in_ch.payload_tag};
                count_nxt = count_r + cnt_t'(1);
              end
            end
            FUNC_SORT: begin
              last_nxt = addr_t'(count_r - cnt_t'(1));
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PASS_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_FIRST: begin
        carry_nxt = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = addr_t'(1);
        pos_nxt   = '0;
      end
      ST_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = swap ? ram_rdata : carry_r;
        carry_nxt = swap ? carry_r : ram_rdata;
        if (pass_more) begin
          ram_re    = 1'b1;
          ram_raddr = pos_r + addr_t'(2);
          pos_nxt   = pos_r + addr_t'(1);
        end
      end
      ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = last_r;
        ram_wdata = carry_r;
        last_nxt  = last_r - addr_t'(1);
      end
      ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        idx_nxt   = '0;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_key_nxt  = rd_key;
          out_tag_nxt  = ram_rdata[TAG_BITS-1:0];
          out_last_nxt = emit_final;
          if (!emit_final) begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + addr_t'(1);
            idx_nxt   = idx_r + addr_t'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      descending_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        descending_r <= cfg_ch.descending;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    carry_r    <= carry_nxt;
    out_key_r  <= out_key_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_RECORDS))
    else $error("record count above capacity");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write hit the same entry");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_LD |-> cnt_t'(idx_r) < count_r)
    else $error("emit position beyond stored records");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && emit_final |=> state_r == ST_IDLE && out_valid_r && out_last_r)
    else $error("final record did not end the run");
`endif

endmodule

// ----- tb/record_key_bubble_sort_tb.sv -----
module record_key_bubble_sort_tb;
  import rkbs_pkg::*;

  // func code the block has no operation for; it must be ignored
  localparam func_t FUNC_NOP = 2'd3;

  localparam int MAX_SHOWN     = 10;      // mismatches printed in full
  localparam int SETTLE_CYCLES = 40;      // quiet time after the last record of a run
  localparam int LONG_HOLD     = 300;     // one long out_ch back-pressure stretch
  localparam int PHASE_ITEMS   = 55;      // effective random items per order phase
  localparam int CYCLE_LIMIT   = 400000;  // watchdog

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
  } sorted_rec_t;

  // Shadow of the record store plus the queue of records the block still owes.
  class sort_checker;
    key_t        keys [MAX_RECORDS];
    tag_t        tags [MAX_RECORDS];
    int          held;
    bit          down;
    sorted_rec_t records_due[$];
    int          mismatches;
    int          results_checked;
    int          runs;
    int          dropped_loads;

    function new();
      held            = 0;
      down            = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      runs            = 0;
      dropped_loads   = 0;
    endfunction

    function void set_order(bit descending);
      down = descending;
    endfunction

    // Apply one accepted item; returns 1 for a clear, a sort or a load that fit.
    function bit note_item(func_t f, key_t k, tag_t t);
      int          pass;
      int          pos;
      key_t        k_swap;
      tag_t        t_swap;
      sorted_rec_t rec;
      case (f)
        FUNC_LOAD: begin
          if (held < MAX_RECORDS) begin
            keys[held] = k;
            tags[held] = t;
            held++;
            return 1'b1;
          end
          dropped_loads++;
          return 1'b0;
        end
        FUNC_CLEAR: begin
          held = 0;
          return 1'b1;
        end
        FUNC_SORT: begin
          // bubble sort, exchanging only strictly out-of-order neighbors
          // so that equal keys stay in load order
          for (pass = 0; pass + 1 < held; pass++) begin
            for (pos = 0; pos + 1 < held - pass; pos++) begin
              if (down ? (keys[pos] < keys[pos+1]) : (keys[pos] > keys[pos+1])) begin
                k_swap      = keys[pos];
                t_swap      = tags[pos];
                keys[pos]   = keys[pos+1];
                tags[pos]   = tags[pos+1];
                keys[pos+1] = k_swap;
                tags[pos+1] = t_swap;
              end
            end
          end
          for (pos = 0; pos < held; pos++) begin
            rec.key  = keys[pos];
            rec.tag  = tags[pos];
            rec.last = (pos == held - 1);
            records_due.push_back(rec);
          end
          if (held > 0) runs++;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void check_result(key_t k, tag_t t, logic l);
      sorted_rec_t exp_rec;
      results_checked++;
      if (records_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch #%0d: record key %h tag %0d last %0b with nothing expected",
                   mismatches, k, t, l);
        return;
      end
      exp_rec = records_due.pop_front();
      if (exp_rec.key !== k || exp_rec.tag !== t || exp_rec.last !== l) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch #%0d: expected key %h tag %0d last %0b, got key %h tag %0d last %0b",
                   mismatches, exp_rec.key, exp_rec.tag, exp_rec.last, k, t, l);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rkbs_in_if  in_ch ();
  rkbs_out_if out_ch ();
  rkbs_cfg_if cfg_ch ();

  record_key_bubble_sort dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sort_checker board = new();

  int items_accepted = 0;
  int items_effective = 0;
  bit sender_gaps = 1'b1;
  int burst_left = 0;
  bit long_hold_done = 1'b0;
  int cycles = 0;

  always #1 clk = ~clk;

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records still due", cycles,
               board.records_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result monitor: every record handed over on out_ch is checked in order.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result(out_ch.sorted_key, out_ch.sorted_tag, out_ch.last);
  end

  // out_ch ready pattern. The mode is redrawn at random among always ready, coin flip,
  // mostly stalled and mostly ready. Once, after 12 records have been checked, ready
  // is held low for a long stretch so the block backs up into in_ch.
  initial begin : out_ready_pattern
    int tick;
    int mode;
    tick = 0;
    mode = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      tick++;
      if (!long_hold_done && board.results_checked >= 12) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else begin
        if (tick % 48 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one item from a falling edge; returns at the falling edge after
  // it is taken. valid is left high so back-to-back items need no gap.
  task automatic send_item(func_t f, key_t k, tag_t t);
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.key_value   <= k;
    in_ch.payload_tag <= t;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_accepted++;
    if (board.note_item(f, k, t)) items_effective++;
    @(negedge clk);
  endtask

  // Sender burst/gap shaping, called after each item.
  task automatic pace();
    int gap;
    if (!sender_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 12);
    gap = $urandom_range(1, 6);
    in_ch.valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic item(func_t f, key_t k, tag_t t);
    send_item(f, k, t);
    pace();
  endtask

  // Stop offering and wait until every owed record has come back, then let
  // the block go quiet (empty sorts and loads leave nothing to wait on).
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.records_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_order(bit descending);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.descending <= descending;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    board.set_order(descending);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Keys lean toward duplicates and extremes so that ties and wrap-free
  // compares at the top of the range get exercised.
  function automatic key_t pick_key();
    case ($urandom_range(0, 5))
      0, 1:    return key_t'($urandom());
      2, 3:    return key_t'($urandom_range(0, 7));
      4:       return ($urandom_range(0, 1) != 0) ? {KEY_BITS{1'b1}} : {KEY_BITS{1'b0}};
      default: return key_t'(32'hFFFF_FFF0 | $urandom_range(0, 15));
    endcase
  endfunction

  function automatic tag_t pick_tag();
    return tag_t'($urandom_range(0, 31));
  endfunction

  // Mostly well-formed runs: optional clear, a batch of loads, a sort.
  // Some batches overflow the store, some skip the sort so records pile up,
  // and an odd unused code is mixed in.
  task automatic run_random(int target, bit fill_first);
    int start;
    int n;
    int i;
    bit first;
    start = items_effective;
    first = fill_first;
    while (items_effective - start < target) begin
      if (first || $urandom_range(0, 9) < 4)
        item(FUNC_CLEAR, pick_key(), pick_tag());
      if (first)
        n = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
      else if ($urandom_range(0, 7) == 0)
        n = $urandom_range(MAX_RECORDS - 4, MAX_RECORDS + 4);
      else
        n = $urandom_range(0, 9);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0)
          item(FUNC_NOP, pick_key(), pick_tag());
        item(FUNC_LOAD, pick_key(), pick_tag());
      end
      if (first || $urandom_range(0, 9) != 0)
        item(FUNC_SORT, pick_key(), pick_tag());
      first = 1'b0;
    end
  endtask

  initial begin : stimulus
    int failures;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_LOAD;
    in_ch.key_value   <= '0;
    in_ch.payload_tag <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.descending <= 1'b0;
    rst_n             <= 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed, ascending ---
    write_order(1'b0);
    item(FUNC_SORT,  32'h0000_0000, 5'd0);   // sort on an empty store
    item(FUNC_NOP,   32'hFFFF_FFFF, 5'd31);  // unused code
    item(FUNC_CLEAR, 32'h0000_0000, 5'd0);   // clear while empty
    item(FUNC_LOAD,  32'h0000_0000, 5'd31);
    item(FUNC_LOAD,  32'hFFFF_FFFF, 5'd0);
    item(FUNC_LOAD,  32'h0000_0005, 5'd1);   // three equal keys: order must hold
    item(FUNC_LOAD,  32'h0000_0005, 5'd2);
    item(FUNC_LOAD,  32'h0000_0005, 5'd3);
    item(FUNC_LOAD,  32'h0000_0000, 5'd4);
    item(FUNC_LOAD,  32'hFFFF_FFFF, 5'd5);
    item(FUNC_LOAD,  32'h8000_0000, 5'd6);   // top bit alone: full-width compare
    item(FUNC_LOAD,  32'h7FFF_FFFF, 5'd10);
    item(FUNC_SORT,  32'h0000_0000, 5'd0);
    item(FUNC_SORT,  32'h0000_0000, 5'd0);   // already in order
    item(FUNC_LOAD,  32'h0000_0001, 5'd7);   // appended after a sort
    item(FUNC_SORT,  32'h0000_0000, 5'd0);
    item(FUNC_CLEAR, 32'h0000_0000, 5'd0);
    item(FUNC_SORT,  32'h0000_0000, 5'd0);   // empty again after clear
    item(FUNC_LOAD,  32'hAAAA_AAAA, 5'd21);
    item(FUNC_SORT,  32'h5555_5555, 5'd10);  // single record, last on the only one
    item(FUNC_NOP,   32'h0000_0000, 5'd0);
    drain_results();

    // --- random phases, order flipped between them while idle ---
    write_order(1'b1);
    sender_gaps = 1'b1;
    run_random(PHASE_ITEMS, 1'b1);
    drain_results();

    write_order(1'b0);
    sender_gaps = 1'b0;                       // back-to-back sender stretch
    run_random(PHASE_ITEMS, 1'b0);
    drain_results();

    write_order(1'b1);
    sender_gaps = 1'b1;
    run_random(PHASE_ITEMS, 1'b0);
    drain_results();

    failures = board.mismatches + board.records_due.size();
    $display("Run covered %0d items (%0d with effect, %0d loads dropped on a full store)",
             items_accepted, items_effective, board.dropped_loads);
    $display("%0d sorted runs in both orders, %0d records checked in %0d cycles",
             board.runs, board.results_checked, cycles);
    if (failures == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rkbs_pkg.sv
sv/rkbs_ifs.sv
sv/rkbs_ram.sv
sv/record_key_bubble_sort.sv
tb/record_key_bubble_sort_tb.sv
